### hw/rtl/bilinear_image_resampler_top_macros.svh
// assertion helpers for the checker file
`ifndef BILINEAR_IMAGE_RESAMPLER_TOP_MACROS_SVH
`define BILINEAR_IMAGE_RESAMPLER_TOP_MACROS_SVH

// concurrent check on the rising clock, quiet while reset is applied
`define BIR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// concurrent check on the rising clock that also holds during reset
`define BIR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/bir_pkg.sv
`default_nettype none
package bir_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_DST_HEIGHT = 2'd3;

  // input opcodes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // neighbour select codes
  localparam logic [1:0] NB_TOP_LEFT  = 2'd0;
  localparam logic [1:0] NB_TOP_RIGHT = 2'd1;
  localparam logic [1:0] NB_BOT_LEFT  = 2'd2;
  localparam logic [1:0] NB_BOT_RIGHT = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       pos_en;
    logic       addr_en;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       lerp_en;
    logic       prod_en;
    logic       sum_en;
  } bir_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic at_origin;
    logic div_busy;
    logic out_busy;
  } bir_status_t;

endpackage
`default_nettype wire

### hw/rtl/bir_div.sv
`default_nettype none
module bir_div #(
  parameter int NW = 24,
  parameter int DW = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               busy_o,
  output logic [NW-1:0]      quot_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   q_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   den_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic [DW:0]     trial;
  logic            ge;
  logic [DW-1:0]   rem_d;

  // one restoring step per cycle
  always_comb begin
    trial = {rem_q, q_q[NW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // quotient and remainder shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      q_q   <= {q_q[NW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;

endmodule
`default_nettype wire

### hw/rtl/bir_datapath.sv
`default_nettype none
module bir_datapath import bir_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int PIXEL_BITS     = 8,
  parameter int FRAC_BITS      = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire bir_cmd_t    cmd_i,
  output bir_status_t      status_o,
  input  wire logic        cfg_valid_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i,
  input  wire logic [7:0]  pixel_in_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [7:0]       pixel_out_o,
  output logic [9:0]       out_col_o,
  output logic [9:0]       out_row_o,
  output logic             last_pixel_o
);

  localparam int F     = FRAC_BITS;
  localparam int PB    = PIXEL_BITS;
  localparam int SW    = $clog2(MAX_SRC_WIDTH);
  localparam int SH    = $clog2(MAX_SRC_HEIGHT);
  localparam int WW    = SW + 1;
  localparam int HW    = SH + 1;
  localparam int CSW   = SW + F;
  localparam int RSW   = SH + F;
  localparam int PXW   = 10 + CSW;
  localparam int PYW   = 10 + RSW;
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = F + PB + 1;
  localparam int SUMW  = 2 * F + PB + 2;

  // configuration registers
  logic [8:0]  src_w_q, src_h_q;
  logic [10:0] dst_w_q, dst_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 9'd256;
      src_h_q <= 9'd256;
      dst_w_q <= 11'd256;
      dst_h_q <= 11'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SRC_WIDTH:  src_w_q <= cfg_data_i[8:0];
        CFG_SRC_HEIGHT: src_h_q <= cfg_data_i[8:0];
        CFG_DST_WIDTH:  dst_w_q <= cfg_data_i;
        CFG_DST_HEIGHT: dst_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [10:0]   dw, dh;

  always_comb begin
    if (src_w_q == 9'd0) begin
      w = WW'(1);
    end else if (32'(src_w_q) > 32'(MAX_SRC_WIDTH)) begin
      w = WW'(MAX_SRC_WIDTH);
    end else begin
      w = WW'(src_w_q);
    end
    if (src_h_q == 9'd0) begin
      h = HW'(1);
    end else if (32'(src_h_q) > 32'(MAX_SRC_HEIGHT)) begin
      h = HW'(MAX_SRC_HEIGHT);
    end else begin
      h = HW'(src_h_q);
    end
    if (dst_w_q < 11'd2) begin
      dw = 11'd2;
    end else if (dst_w_q > 11'd1024) begin
      dw = 11'd1024;
    end else begin
      dw = dst_w_q;
    end
    if (dst_h_q < 11'd2) begin
      dh = 11'd2;
    end else if (dst_h_q > 11'd1024) begin
      dh = 11'd1024;
    end else begin
      dh = dst_h_q;
    end
  end

  // load address counter, wraps after the last source pixel
  logic [AW-1:0]      load_idx_q;
  logic [WW+HW-1:0]   src_area;

  assign src_area = (WW + HW)'(w) * (WW + HW)'(h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_idx_q <= '0;
    end else if (cmd_i.load) begin
      if ((32'(load_idx_q) + 32'd1) >= 32'(src_area)) begin
        load_idx_q <= '0;
      end else begin
        load_idx_q <= load_idx_q + AW'(1);
      end
    end
  end

  // step dividers
  logic [CSW-1:0] col_step;
  logic [RSW-1:0] row_step;
  logic           col_busy, row_busy;

  bir_div #(.NW(CSW), .DW(10)) u_col_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  ({SW'(w - WW'(1)), {F{1'b0}}}),
    .den_i  (10'(dw - 11'd1)),
    .busy_o (col_busy),
    .quot_o (col_step)
  );

  bir_div #(.NW(RSW), .DW(10)) u_row_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  ({SH'(h - HW'(1)), {F{1'b0}}}),
    .den_i  (10'(dh - 11'd1)),
    .busy_o (row_busy),
    .quot_o (row_step)
  );

  // output position counters
  logic [9:0] emit_col_q, emit_row_q;
  logic [10:0] col_p1, row_p1;
  logic        last;

  assign col_p1 = {1'b0, emit_col_q} + 11'd1;
  assign row_p1 = {1'b0, emit_row_q} + 11'd1;
  assign last   = (col_p1 >= dw) && (row_p1 >= dh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_col_q <= '0;
      emit_row_q <= '0;
    end else if (cmd_i.sum_en) begin
      if (col_p1 < dw) begin
        emit_col_q <= col_p1[9:0];
      end else begin
        emit_col_q <= '0;
        emit_row_q <= (row_p1 < dh) ? row_p1[9:0] : 10'd0;
      end
    end
  end

  // source position products
  logic [PXW-1:0] px_q;
  logic [PYW-1:0] py_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_en) begin
      px_q <= emit_col_q * col_step;
      py_q <= emit_row_q * row_step;
    end
  end

  // neighbour coordinates, weights and row base addresses
  logic [PXW-F-1:0] ix;
  logic [PYW-F-1:0] iy;
  logic [SW-1:0]    x1;
  logic [SH-1:0]    y1;
  logic [SW-1:0]    x1_q;
  logic [F-1:0]     fx_q, fy_q;
  logic             x_ok_q, y_ok_q;
  logic [AW-1:0]    rb0_q;

  always_comb begin
    ix = px_q[PXW-1:F];
    iy = py_q[PYW-1:F];
    x1 = (ix >= (PXW - F)'(w)) ? SW'(w - WW'(1)) : SW'(ix);
    y1 = (iy >= (PYW - F)'(h)) ? SH'(h - HW'(1)) : SH'(iy);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_en) begin
      x1_q   <= x1;
      fx_q   <= px_q[F-1:0];
      fy_q   <= py_q[F-1:0];
      x_ok_q <= (WW'(x1) + WW'(1)) < w;
      y_ok_q <= (HW'(y1) + HW'(1)) < h;
      rb0_q  <= AW'(y1) * AW'(w);
    end
  end

  // frame store, one write or one read per cycle
  logic [PB-1:0] mem [DEPTH];
  logic [PB-1:0] rdata_q;
  logic [AW-1:0] rd_base;
  logic [AW-1:0] rd_addr;

  assign rd_base = cmd_i.rd_sel[1] ? (rb0_q + AW'(w)) : rb0_q;
  assign rd_addr = rd_base + AW'(x1_q) + AW'(cmd_i.rd_sel[0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[load_idx_q] <= PB'(pixel_in_i);
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // capture neighbours in the cycle after each read, outside ones read as zero
  logic          rd_vld_q;
  logic [1:0]    rd_sel_q;
  logic [PB-1:0] nb_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_sel_q <= NB_TOP_LEFT;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      rd_sel_q <= cmd_i.rd_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      case (rd_sel_q)
        NB_TOP_LEFT:  nb_q[0] <= rdata_q;
        NB_TOP_RIGHT: nb_q[1] <= x_ok_q ? rdata_q : '0;
        NB_BOT_LEFT:  nb_q[2] <= y_ok_q ? rdata_q : '0;
        NB_BOT_RIGHT: nb_q[3] <= (x_ok_q && y_ok_q) ? rdata_q : '0;
        default: ;
      endcase
    end
  end

  // horizontal interpolation
  logic [F:0]    wx0, wy0;
  logic [TW-1:0] top_q, bot_q;

  assign wx0 = {1'b1, {F{1'b0}}} - (F + 1)'(fx_q);
  assign wy0 = {1'b1, {F{1'b0}}} - (F + 1)'(fy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.lerp_en) begin
      top_q <= wx0 * nb_q[0] + fx_q * nb_q[1];
      bot_q <= wx0 * nb_q[2] + fx_q * nb_q[3];
    end
  end

  // vertical weights as split partial products
  logic [2*F:0]      lo0_q, lo1_q;
  logic [F+PB+1:0]   hi0_q, hi1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) begin
      lo0_q <= wy0 * top_q[F-1:0];
      lo1_q <= fy_q * bot_q[F-1:0];
      hi0_q <= wy0 * top_q[TW-1:F];
      hi1_q <= fy_q * bot_q[TW-1:F];
    end
  end

  // final sum and output register
  logic [SUMW-1:0] sum;
  logic            out_valid_q;
  logic [7:0]      pix_q;
  logic [9:0]      col_q, row_q;
  logic            last_q;

  assign sum = (SUMW'(SUMW'(hi0_q) + SUMW'(hi1_q)) << F) + SUMW'(lo0_q) + SUMW'(lo1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.sum_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      pix_q  <= 8'(sum[2*F +: PB]);
      col_q  <= emit_col_q;
      row_q  <= emit_row_q;
      last_q <= last;
    end
  end

  assign status_o.at_origin = (emit_col_q == 10'd0) && (emit_row_q == 10'd0);
  assign status_o.div_busy  = col_busy || row_busy;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pix_q;
  assign out_col_o    = col_q;
  assign out_row_o    = row_q;
  assign last_pixel_o = last_q;

endmodule
`default_nettype wire

### hw/rtl/bir_ctrl.sv
`default_nettype none
module bir_ctrl import bir_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        opcode_i,
  output logic             in_ready_o,
  input  wire bir_status_t status_i,
  output bir_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_POS,
    ST_ADDR,
    ST_RD,
    ST_CAP,
    ST_LERP,
    ST_PROD,
    ST_SUM
  } state_e;

  state_e     state_q;
  logic [1:0] rd_cnt_q;
  logic       in_xfer;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = in_xfer && (opcode_i == OP_LOAD);
    cmd_o.div_start = in_xfer && (opcode_i == OP_REQUEST) && status_i.at_origin;
    cmd_o.pos_en    = (state_q == ST_POS);
    cmd_o.addr_en   = (state_q == ST_ADDR);
    cmd_o.rd_en     = (state_q == ST_RD);
    cmd_o.rd_sel    = rd_cnt_q;
    cmd_o.lerp_en   = (state_q == ST_LERP);
    cmd_o.prod_en   = (state_q == ST_PROD);
    cmd_o.sum_en    = (state_q == ST_SUM) && !status_i.out_busy;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_cnt_q <= NB_TOP_LEFT;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && (opcode_i == OP_REQUEST)) begin
            state_q <= status_i.at_origin ? ST_DIV : ST_POS;
          end
        end
        ST_DIV: begin
          if (!status_i.div_busy) begin
            state_q <= ST_POS;
          end
        end
        ST_POS: state_q <= ST_ADDR;
        ST_ADDR: begin
          state_q  <= ST_RD;
          rd_cnt_q <= NB_TOP_LEFT;
        end
        ST_RD: begin
          rd_cnt_q <= rd_cnt_q + 2'd1;
          if (rd_cnt_q == NB_BOT_RIGHT) begin
            state_q <= ST_CAP;
          end
        end
        ST_CAP:  state_q <= ST_LERP;
        ST_LERP: state_q <= ST_PROD;
        ST_PROD: state_q <= ST_SUM;
        ST_SUM: begin
          if (!status_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bilinear_image_resampler_top.sv
// channel | direction | payload                                          | handshake
// cfg     | in        | cfg_index_i, cfg_data_i                          | cfg_valid_i / cfg_ready_o
// in      | in        | opcode_i, pixel_in_i                             | in_valid_i / in_ready_o
// out     | out       | pixel_out_o, out_col_o, out_row_o, last_pixel_o  | out_valid_o / out_ready_i
//
// a load transfer writes the pixel straight into the frame store
// an output request runs POS, ADDR, four single-port frame store reads, CAP, LERP, PROD, SUM
// the first pixel of an image also runs the step divide
// reset clears control state and sets the configuration registers to 256, the frame store holds nothing until loaded
// a result waiting on out_ready_i does not block loads, a second request waits for it
`default_nettype none
module bilinear_image_resampler_top import bir_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int PIXEL_BITS     = 8,
  parameter int FRAC_BITS      = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [7:0]  pixel_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       pixel_out_o,
  output logic [9:0]       out_col_o,
  output logic [9:0]       out_row_o,
  output logic             last_pixel_o
);

  bir_cmd_t    cmd;
  bir_status_t status;

  assign cfg_ready_o = 1'b1;

  // sequencer
  bir_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .opcode_i  (opcode_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // frame store and arithmetic
  bir_datapath #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
    .PIXEL_BITS    (PIXEL_BITS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_in_i  (pixel_in_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .pixel_out_o (pixel_out_o),
    .out_col_o   (out_col_o),
    .out_row_o   (out_row_o),
    .last_pixel_o(last_pixel_o)
  );

endmodule
`default_nettype wire

### hw/rtl/bir_checker.sv
`default_nettype none
`include "bilinear_image_resampler_top_macros.svh"
module bir_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        opcode_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  pixel_out_o,
  input wire logic [9:0]  out_col_o,
  input wire logic [9:0]  out_row_o,
  input wire logic        last_pixel_o
);

  // a stalled result holds
  `BIR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_out_o), "result changed while stalled")

  // an output request keeps the input side closed while it is worked on
  `BIR_ASSERT(a_req_busy, in_valid_i && in_ready_o && opcode_i |=> !in_ready_o, "input open during a request")

  // a new result only appears from a busy request
  `BIR_ASSERT(a_result_src, $rose(out_valid_o) |-> $past(!in_ready_o), "result without a request")

  // the last pixel is never in column or row zero
  `BIR_ASSERT(a_last_pos, out_valid_o && last_pixel_o |-> out_col_o != 10'd0 && out_row_o != 10'd0, "bad last pixel position")

endmodule

bind bilinear_image_resampler_top bir_checker u_bir_checker (.*);
`default_nettype wire
